// ----- design/bts_pkg.sv -----
// ----------------------------------------------------------------------------
// bts_pkg
// Types and constants shared by the bilinear texture sampler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

  localparam int COORD_W     = 24;
  localparam int ADDR_W      = 16;
  localparam int TEXEL_W     = 32;
  localparam int STORE_DEPTH = 65536;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 3;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_PAD     = 2'd1;
  localparam logic [1:0] MODE_REPEAT  = 2'd2;
  localparam logic [1:0] MODE_REFLECT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY    = 3'd5;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [ADDR_W-1:0]          texel_index;
    logic [TEXEL_W-1:0]         texel_rgba;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_r;
    logic [7:0] out_g;
    logic [7:0] out_b;
    logic [7:0] out_a;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/bts_ram.sv -----
// ----------------------------------------------------------------------------
// bts_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- design/bts_axis.sv -----
// ----------------------------------------------------------------------------
// bts_axis
// Pipelined edge-rule resolver for one axis: floor position and its right
// neighbor mapped by none, pad, repeat or reflect, two remainder bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_axis #(
  parameter int PW = 17,
  parameter int NW = 9
) (
  input  wire logic                 clk,
  input  wire logic signed [PW-1:0] pos,
  input  wire logic [NW-1:0]        size,
  input  wire logic [1:0]           mode,
  output logic      [NW-1:0]        idx0_r,
  output logic      [NW-1:0]        idx1_r,
  output logic                      ok0_r,
  output logic                      ok1_r
);

  localparam int AW  = PW - 1;
  localparam int STG = (AW + 1) / 2;
  localparam int DW  = NW + 1;

  function automatic logic [DW-1:0] mod_step(input logic [DW-1:0] rem, input logic b,
                                             input logic [DW-1:0] m);
    logic [DW:0] t;
    t = {rem, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[DW-1:0];
  endfunction

  logic [DW-1:0]        modulus;
  logic [DW-1:0]        rem_r  [0:STG];
  logic [AW-1:0]        a_r    [0:STG];
  logic signed [PW-1:0] p_r    [0:STG];
  logic [DW-1:0]        rem_nxt[0:STG-1];

  assign modulus = (mode == bts_pkg::MODE_REFLECT) ? {size, 1'b0} : {1'b0, size};

  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    a_r[0]   <= pos[PW-1] ? ~pos[AW-1:0] : pos[AW-1:0];
    p_r[0]   <= pos;
  end

  for (genvar s = 0; s < STG; s++) begin : g_stage
    localparam int HI = AW - 1 - 2 * s;
    localparam int LO = (AW - 2 - 2 * s >= 0) ? AW - 2 - 2 * s : 0;
    localparam bit TWO = (AW - 2 - 2 * s >= 0);

    assign rem_nxt[s] = TWO ? mod_step(mod_step(rem_r[s], a_r[s][HI], modulus),
                                       a_r[s][LO], modulus)
                            : mod_step(rem_r[s], a_r[s][HI], modulus);

    always_ff @(posedge clk) begin
      rem_r[s+1] <= rem_nxt[s];
      a_r[s+1]   <= a_r[s];
      p_r[s+1]   <= p_r[s];
    end
  end

  logic [DW-1:0]        pm, pm1, size2;
  logic signed [PW:0]   pv0, pv1, ns;
  logic [NW-1:0]        idx0_nxt, idx1_nxt;
  logic                 ok0_nxt, ok1_nxt;

  assign size2 = {size, 1'b0};
  assign pm    = p_r[STG][PW-1] ? modulus - DW'(1) - rem_r[STG] : rem_r[STG];
  assign pm1   = (pm + DW'(1) == modulus) ? '0 : pm + DW'(1);
  assign pv0   = (PW+1)'(p_r[STG]);
  assign pv1   = pv0 + (PW+1)'(1);
  assign ns    = (PW+1)'(size);

  always_comb begin
    idx0_nxt = NW'(pv0);
    idx1_nxt = NW'(pv1);
    ok0_nxt  = 1'b1;
    ok1_nxt  = 1'b1;
    case (mode)
      bts_pkg::MODE_PAD: begin
        idx0_nxt = (pv0 < 0) ? '0 : ((pv0 >= ns) ? size - NW'(1) : NW'(pv0));
        idx1_nxt = (pv1 < 0) ? '0 : ((pv1 >= ns) ? size - NW'(1) : NW'(pv1));
      end
      bts_pkg::MODE_REPEAT: begin
        idx0_nxt = NW'(pm);
        idx1_nxt = NW'(pm1);
      end
      bts_pkg::MODE_REFLECT: begin
        idx0_nxt = (pm  < {1'b0, size}) ? NW'(pm)  : NW'(size2 - DW'(1) - pm);
        idx1_nxt = (pm1 < {1'b0, size}) ? NW'(pm1) : NW'(size2 - DW'(1) - pm1);
      end
      default: begin
        ok0_nxt = (pv0 >= 0) && (pv0 < ns);
        ok1_nxt = (pv1 >= 0) && (pv1 < ns);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx0_r <= idx0_nxt;
    idx1_r <= idx1_nxt;
    ok0_r  <= ok0_nxt;
    ok1_r  <= ok1_nxt;
  end

endmodule

`default_nettype wire

// ----- design/bilinear_texture_sampler.sv -----
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// RGBA texture store with bilinear sampling or a fast single-texel mode, edge rules and opacity.
// Pipeline: axis resolvers with a delay line alongside, then stages b to f:
// row bases and weights, store access, weighted channels, rounded sum, opacity.
// Throughput: one transaction per cycle; busy stays low, out_valid is a pulse.
// Reset sets configuration to defaults and clears valid bits; texture contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_texture_sampler #(
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256,
  parameter int SUBPIXEL_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire bts_pkg::in_item_t                 in_item,
  output logic                                   out_valid,
  output bts_pkg::out_item_t                     out_item,
  input  wire logic                              cfg_we,
  input  wire logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bts_pkg::CFG_W-1:0]         cfg_data
);

  localparam int SP    = SUBPIXEL_BITS;
  localparam int PW    = bts_pkg::COORD_W + 1 - SP;
  localparam int STG   = (PW - 1 + 1) / 2;
  localparam int LAT   = STG + 2;
  localparam int NMX   = (MAX_WIDTH  < 511) ? MAX_WIDTH  : 511;
  localparam int NMY   = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
  localparam int NWX   = $clog2(NMX + 1);
  localparam int NWY   = $clog2(NMY + 1);
  localparam int WW    = 2 * SP + 1;
  localparam int SW    = 2 * SP + 8;
  localparam int AW    = bts_pkg::ADDR_W;
  localparam int TW    = bts_pkg::TEXEL_W;

  // configuration
  logic [8:0] tex_width_r, tex_height_r;
  logic [1:0] h_mode_r, v_mode_r;
  logic       fast_mode_r;
  logic [7:0] opacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= 9'd256;
      tex_height_r <= 9'd256;
      h_mode_r     <= bts_pkg::MODE_NONE;
      v_mode_r     <= bts_pkg::MODE_NONE;
      fast_mode_r  <= 1'b0;
      opacity_r    <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        bts_pkg::REG_TEX_WIDTH:  tex_width_r  <= cfg_data;
        bts_pkg::REG_TEX_HEIGHT: tex_height_r <= cfg_data;
        bts_pkg::REG_H_MODE:     h_mode_r     <= cfg_data[1:0];
        bts_pkg::REG_V_MODE:     v_mode_r     <= cfg_data[1:0];
        bts_pkg::REG_FAST_MODE:  fast_mode_r  <= cfg_data[0];
        bts_pkg::REG_OPACITY:    opacity_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [NWX-1:0] nx;
  logic [NWY-1:0] ny;
  logic [8:0]     mult;

  assign nx = (tex_width_r == '0) ? NWX'(1) :
              ((32'(tex_width_r) > MAX_WIDTH) ? NWX'(MAX_WIDTH) : NWX'(tex_width_r));
  assign ny = (tex_height_r == '0) ? NWY'(1) :
              ((32'(tex_height_r) > MAX_HEIGHT) ? NWY'(MAX_HEIGHT) : NWY'(tex_height_r));
  assign mult = {1'b0, opacity_r} + 9'(opacity_r[7]);

  assign busy = 1'b0;

  // accept: half-pixel offset and split
  logic                 acc;
  logic signed [PW+SP-1:0] xh, yh;

  assign acc = start && !busy;
  assign xh  = {in_item.coord_x[bts_pkg::COORD_W-1], in_item.coord_x} - (PW+SP)'(1 << (SP - 1));
  assign yh  = {in_item.coord_y[bts_pkg::COORD_W-1], in_item.coord_y} - (PW+SP)'(1 << (SP - 1));

  logic [NWX-1:0] rx0, rx1;
  logic [NWY-1:0] ry0, ry1;
  logic           okx0, okx1, oky0, oky1;

  bts_axis #(.PW(PW), .NW(NWX)) u_axis_x (
    .clk(clk), .pos(xh[PW+SP-1:SP]), .size(nx), .mode(h_mode_r),
    .idx0_r(rx0), .idx1_r(rx1), .ok0_r(okx0), .ok1_r(okx1)
  );

  bts_axis #(.PW(PW), .NW(NWY)) u_axis_y (
    .clk(clk), .pos(yh[PW+SP-1:SP]), .size(ny), .mode(v_mode_r),
    .idx0_r(ry0), .idx1_r(ry1), .ok0_r(oky0), .ok1_r(oky1)
  );

  // delay line alongside the axis resolvers
  logic          d_vld_r  [0:LAT-1];
  logic          d_op_r   [0:LAT-1];
  logic [SP-1:0] d_fx_r   [0:LAT-1];
  logic [SP-1:0] d_fy_r   [0:LAT-1];
  logic [AW-1:0] d_idx_r  [0:LAT-1];
  logic [TW-1:0] d_rgba_r [0:LAT-1];

  always_ff @(posedge clk) begin
    d_op_r[0]   <= in_item.op;
    d_fx_r[0]   <= xh[SP-1:0];
    d_fy_r[0]   <= yh[SP-1:0];
    d_idx_r[0]  <= in_item.texel_index;
    d_rgba_r[0] <= in_item.texel_rgba;
    for (int k = 1; k < LAT; k++) begin
      d_op_r[k]   <= d_op_r[k-1];
      d_fx_r[k]   <= d_fx_r[k-1];
      d_fy_r[k]   <= d_fy_r[k-1];
      d_idx_r[k]  <= d_idx_r[k-1];
      d_rgba_r[k] <= d_rgba_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        d_vld_r[k] <= 1'b0;
      end
    end else begin
      d_vld_r[0] <= acc;
      for (int k = 1; k < LAT; k++) begin
        d_vld_r[k] <= d_vld_r[k-1];
      end
    end
  end

  // stage b: row bases and weights
  logic [NWX+NWY-1:0] b_base0_r, b_base1_r;
  logic [NWX-1:0]     b_rx0_r, b_rx1_r;
  logic [3:0]         b_ok_r;
  logic [WW-1:0]      b_w_r [0:3];
  logic               b_load_r, b_smp_r;
  logic [AW-1:0]      b_idx_r;
  logic [TW-1:0]      b_rgba_r;
  logic [SP:0]        ifx, ify, ffx, ffy;
  logic [WW-1:0]      w_nxt [0:3];

  assign ffx = {1'b0, d_fx_r[LAT-1]};
  assign ffy = {1'b0, d_fy_r[LAT-1]};
  assign ifx = (SP+1)'(1 << SP) - ffx;
  assign ify = (SP+1)'(1 << SP) - ffy;

  always_comb begin
    if (fast_mode_r) begin
      w_nxt[0] = WW'(1 << (2 * SP));
      w_nxt[1] = '0;
      w_nxt[2] = '0;
      w_nxt[3] = '0;
    end else begin
      w_nxt[0] = WW'(ifx) * WW'(ify);
      w_nxt[1] = WW'(ffx) * WW'(ify);
      w_nxt[2] = WW'(ifx) * WW'(ffy);
      w_nxt[3] = WW'(ffx) * WW'(ffy);
    end
  end

  always_ff @(posedge clk) begin
    b_base0_r <= nx * ry0;
    b_base1_r <= nx * ry1;
    b_rx0_r   <= rx0;
    b_rx1_r   <= rx1;
    b_ok_r    <= {okx1 & oky1, okx0 & oky1, okx1 & oky0, okx0 & oky0};
    for (int k = 0; k < 4; k++) begin
      b_w_r[k] <= w_nxt[k];
    end
    b_idx_r   <= d_idx_r[LAT-1];
    b_rgba_r  <= d_rgba_r[LAT-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_load_r <= 1'b0;
      b_smp_r  <= 1'b0;
    end else begin
      b_load_r <= d_vld_r[LAT-1] && (d_op_r[LAT-1] == bts_pkg::OP_LOAD);
      b_smp_r  <= d_vld_r[LAT-1] && (d_op_r[LAT-1] == bts_pkg::OP_SAMPLE);
    end
  end

  // stage c: addresses, store access
  logic [AW-1:0] addr00, addr10, addr01, addr11;
  logic [TW-1:0] t00, t10, t01, t11;

  assign addr00 = AW'(b_base0_r) + AW'(b_rx0_r);
  assign addr10 = AW'(b_base0_r) + AW'(b_rx1_r);
  assign addr01 = AW'(b_base1_r) + AW'(b_rx0_r);
  assign addr11 = AW'(b_base1_r) + AW'(b_rx1_r);

  bts_ram #(.WIDTH(TW), .DEPTH(bts_pkg::STORE_DEPTH)) u_ram_row0 (
    .clk(clk), .we(b_load_r), .waddr(b_idx_r), .wdata(b_rgba_r),
    .raddr_a(addr00), .rdata_a(t00), .raddr_b(addr10), .rdata_b(t10)
  );

  bts_ram #(.WIDTH(TW), .DEPTH(bts_pkg::STORE_DEPTH)) u_ram_row1 (
    .clk(clk), .we(b_load_r), .waddr(b_idx_r), .wdata(b_rgba_r),
    .raddr_a(addr01), .rdata_a(t01), .raddr_b(addr11), .rdata_b(t11)
  );

  logic [3:0]    c_ok_r;
  logic [WW-1:0] c_w_r [0:3];
  logic          c_smp_r;

  always_ff @(posedge clk) begin
    c_ok_r <= b_ok_r;
    for (int k = 0; k < 4; k++) begin
      c_w_r[k] <= b_w_r[k];
    end
  end

  // stage d: weighted channels
  logic [TW-1:0]     tex [0:3];
  logic [WW+7:0]     d_prod_r [0:3][0:3];
  logic              d_smp_r;

  assign tex[0] = c_ok_r[0] ? t00 : '0;
  assign tex[1] = c_ok_r[1] ? t10 : '0;
  assign tex[2] = c_ok_r[2] ? t01 : '0;
  assign tex[3] = c_ok_r[3] ? t11 : '0;

  always_ff @(posedge clk) begin
    for (int t = 0; t < 4; t++) begin
      for (int c = 0; c < 4; c++) begin
        d_prod_r[t][c] <= c_w_r[t] * tex[t][8*c +: 8];
      end
    end
  end

  // stage e: rounded sum
  logic [7:0] e_ch_r [0:3];
  logic       e_smp_r;
  logic [SW-1:0] sum [0:3];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = SW'(1 << (2 * SP - 1)) + SW'(d_prod_r[0][c]) + SW'(d_prod_r[1][c])
             + SW'(d_prod_r[2][c]) + SW'(d_prod_r[3][c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      e_ch_r[c] <= sum[c][2*SP +: 8];
    end
  end

  // stage f: opacity
  logic [16:0] scaled [0:3];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      scaled[c] = mult * e_ch_r[c];
    end
  end

  always_ff @(posedge clk) begin
    out_item.out_r <= scaled[0][15:8];
    out_item.out_g <= scaled[1][15:8];
    out_item.out_b <= scaled[2][15:8];
    out_item.out_a <= scaled[3][15:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_smp_r   <= 1'b0;
      d_smp_r   <= 1'b0;
      e_smp_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      c_smp_r   <= b_smp_r;
      d_smp_r   <= c_smp_r;
      e_smp_r   <= d_smp_r;
      out_valid <= e_smp_r;
    end
  end

endmodule

`default_nettype wire
